// ----- sv/sptft_pkg.sv -----
// types and constants shared by the scratchpad tile fill tracker
package sptft_pkg;

    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 16;
    localparam int CNT_W      = 16;
    localparam int OCC_W      = 24;
    localparam int BB_W       = 25;
    localparam int RB_W       = 9;
    localparam int CMD_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    localparam logic [OCC_W-1:0] OCC_MAX       = '1;
    localparam logic [BB_W-1:0]  BANK_BYTES_RST = BB_W'(65536);
    localparam logic [RB_W-1:0]  REQ_BYTES_RST  = RB_W'(32);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOCATE = 3'd0,
        CMD_FILL     = 3'd1,
        CMD_COUNT_UP = 3'd2,
        CMD_FLUSH    = 3'd3,
        CMD_LOOKUP   = 3'd4,
        CMD_PRESENT  = 3'd5,
        CMD_ROOM     = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_NO_ROOM       = 3'd1,
        ST_DUPLICATE     = 3'd2,
        ST_SIZE_MISMATCH = 3'd3,
        ST_NOT_ALLOCATED = 3'd4,
        ST_NOT_PENDING   = 3'd5,
        ST_TABLE_FULL    = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BANK_BYTES    = 2'd0,
        CFG_REQUEST_BYTES = 2'd1,
        CFG_ACCUMULATE    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              bank;
        logic [ADDR_W-1:0] tile_address;
        logic [SIZE_W-1:0] size_units;
        logic [CNT_W-1:0]  request_count;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic             newly_allocated;
        logic             hit;
        logic             present;
        logic             fits;
        logic             below_capacity;
        logic [OCC_W-1:0] occupancy_units;
    } t_out_item;

    typedef struct packed {
        logic [BB_W-1:0] bank_bytes;
        logic [RB_W-1:0] request_bytes;
        logic            accumulate_mode;
    } t_cfg;

endpackage

// ----- sv/sptft_ram.sv -----
// generic simple dual port ram with registered read
module sptft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/sptft_bank.sv -----
// one bank: tag match, slot table, pending counts and occupancy
module sptft_bank #(
    parameter int SLOTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_a_sel,
    input  logic [sptft_pkg::ADDR_W-1:0]        i_a_addr,
    input  logic                                i_b_sel,
    input  sptft_pkg::t_in_item                 i_b_item,
    input  sptft_pkg::t_cfg                     i_cfg,
    output sptft_pkg::t_out_item                o_res
);
    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DW   = sptft_pkg::SIZE_W + sptft_pkg::CNT_W;
    localparam int OB_W = sptft_pkg::OCC_W + sptft_pkg::RB_W;
    localparam int SB_W = sptft_pkg::SIZE_W + sptft_pkg::RB_W;
    localparam int TB_W = OB_W + 1;
    localparam int UW   = sptft_pkg::OCC_W + 2;

    // slot state
    logic [SLOTS-1:0]                 r_used, n_used;
    logic [SLOTS-1:0]                 r_ready, n_ready;
    logic [sptft_pkg::ADDR_W-1:0]     r_tag [SLOTS];
    logic [sptft_pkg::OCC_W-1:0]      r_occ, n_occ;

    // match carried from the compare stage
    logic                             r_m_hit;
    logic [SW-1:0]                    r_m_idx;
    logic                             r_fwd;
    logic [DW-1:0]                    r_fwd_data;

    logic [SLOTS-1:0]                 cam_vec;
    logic                             cam_hit;
    logic [SW-1:0]                    cam_idx;
    logic                             a_hit;
    logic [SW-1:0]                    a_idx;

    logic                             ram_we;
    logic [SW-1:0]                    ram_waddr;
    logic [DW-1:0]                    ram_wdata;
    logic [DW-1:0]                    ram_rdata;

    logic [DW-1:0]                    entry;
    logic [sptft_pkg::SIZE_W-1:0]     e_units;
    logic [sptft_pkg::CNT_W-1:0]      e_pend;
    logic                             rdy0;
    logic [SLOTS-1:0]                 free_vec;
    logic [SLOTS-1:0]                 free_low;
    logic                             f_any;
    logic [SW-1:0]                    f_idx;

    logic [OB_W-1:0]                  occ_bytes;
    logic [SB_W-1:0]                  size_bytes;
    logic [TB_W-1:0]                  sum1, sum2, bb;
    logic [UW-1:0]                    u1, u2;
    logic                             room0, fits_ins, fits_flush;
    logic                             below0, below_ins, below_flush;

    sptft_pkg::t_status               status;
    logic                             ins, fill_ok, cup_ok, flush;
    logic                             present1, ready1;

    // ---- compare stage ----
    always_comb begin
        cam_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            cam_vec[i] = r_used[i] && (r_tag[i] == i_a_addr);
            if (cam_vec[i]) begin
                cam_idx = cam_idx | SW'(i);
            end
        end
    end

    assign cam_hit = |cam_vec;

    // the beat one stage ahead may insert this address or flush the bank
    always_comb begin
        a_hit = cam_hit;
        a_idx = cam_idx;
        if (i_b_sel && ins && (i_b_item.tile_address == i_a_addr)) begin
            a_hit = 1'b1;
            a_idx = f_idx;
        end else if (i_b_sel && flush) begin
            a_hit = 1'b0;
        end
    end

    sptft_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (a_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_hit <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            r_m_hit <= i_a_sel && a_hit;
            r_fwd   <= ram_we && (ram_waddr == a_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_idx    <= a_idx;
        r_fwd_data <= ram_wdata;
    end

    // ---- update stage ----
    assign entry   = r_fwd ? r_fwd_data : ram_rdata;
    assign e_units = entry[DW-1:sptft_pkg::CNT_W];
    assign e_pend  = entry[sptft_pkg::CNT_W-1:0];
    assign rdy0    = r_ready[r_m_idx];

    // lowest free slot
    assign free_vec = ~r_used;
    assign free_low = free_vec & (~free_vec + SLOTS'(1));
    assign f_any    = |free_vec;

    always_comb begin
        f_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (free_low[i]) begin
                f_idx = f_idx | SW'(i);
            end
        end
    end

    assign occ_bytes  = OB_W'(r_occ) * OB_W'(i_cfg.request_bytes);
    assign size_bytes = SB_W'(i_b_item.size_units) * SB_W'(i_cfg.request_bytes);
    assign sum1       = TB_W'(occ_bytes) + TB_W'(size_bytes);
    assign sum2       = sum1 + TB_W'(size_bytes);
    assign bb         = TB_W'(i_cfg.bank_bytes);
    assign u1         = UW'(r_occ) + UW'(i_b_item.size_units);
    assign u2         = u1 + UW'(i_b_item.size_units);

    assign room0       = (u1 <= UW'(sptft_pkg::OCC_MAX)) && (sum1 <= bb);
    assign fits_ins    = (u2 <= UW'(sptft_pkg::OCC_MAX)) && (sum2 <= bb);
    assign fits_flush  = (TB_W'(size_bytes) <= bb);
    assign below0      = (TB_W'(occ_bytes) < bb);
    assign below_ins   = (sum1 < bb);
    assign below_flush = (bb != '0);

    always_comb begin
        status  = sptft_pkg::ST_OK;
        ins     = 1'b0;
        fill_ok = 1'b0;
        cup_ok  = 1'b0;
        flush   = 1'b0;
        case (sptft_pkg::t_cmd'(i_b_item.command))
            sptft_pkg::CMD_ALLOCATE: begin
                if (r_m_hit) begin
                    if (!i_cfg.accumulate_mode) begin
                        status = sptft_pkg::ST_DUPLICATE;
                    end else if (e_units != i_b_item.size_units) begin
                        status = sptft_pkg::ST_SIZE_MISMATCH;
                    end
                end else if (!room0) begin
                    status = sptft_pkg::ST_NO_ROOM;
                end else if (!f_any) begin
                    status = sptft_pkg::ST_TABLE_FULL;
                end else begin
                    ins = 1'b1;
                end
            end
            sptft_pkg::CMD_FILL: begin
                if (!r_m_hit) begin
                    status = sptft_pkg::ST_NOT_ALLOCATED;
                end else if (rdy0 || (e_pend == '0)) begin
                    status = sptft_pkg::ST_NOT_PENDING;
                end else begin
                    fill_ok = 1'b1;
                end
            end
            sptft_pkg::CMD_COUNT_UP: begin
                if (!r_m_hit) begin
                    status = sptft_pkg::ST_NOT_ALLOCATED;
                end else begin
                    cup_ok = 1'b1;
                end
            end
            sptft_pkg::CMD_FLUSH: begin
                flush = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // state after the step
    always_comb begin
        present1 = ins || (r_m_hit && !flush);
        if (ins || cup_ok) begin
            ready1 = 1'b0;
        end else if (fill_ok) begin
            ready1 = (e_pend == sptft_pkg::CNT_W'(1));
        end else begin
            ready1 = rdy0;
        end

        o_res                 = '0;
        o_res.status          = status;
        o_res.newly_allocated = ins;
        o_res.present         = present1;
        o_res.hit             = present1 && ready1;
        if (ins) begin
            o_res.fits            = fits_ins;
            o_res.below_capacity  = below_ins;
            o_res.occupancy_units = r_occ + sptft_pkg::OCC_W'(i_b_item.size_units);
        end else if (flush) begin
            o_res.fits            = fits_flush;
            o_res.below_capacity  = below_flush;
            o_res.occupancy_units = '0;
        end else begin
            o_res.fits            = room0;
            o_res.below_capacity  = below0;
            o_res.occupancy_units = r_occ;
        end
    end

    always_comb begin
        ram_we    = i_b_sel && (ins || fill_ok || cup_ok);
        ram_waddr = ins ? f_idx : r_m_idx;
        if (ins) begin
            ram_wdata = {i_b_item.size_units, i_b_item.request_count};
        end else if (fill_ok) begin
            ram_wdata = {e_units, e_pend - sptft_pkg::CNT_W'(1)};
        end else if (e_pend != '1) begin
            ram_wdata = {e_units, e_pend + sptft_pkg::CNT_W'(1)};
        end else begin
            ram_wdata = entry;
        end
    end

    always_comb begin
        n_used  = r_used;
        n_ready = r_ready;
        n_occ   = r_occ;
        if (i_b_sel) begin
            n_occ = o_res.occupancy_units;
            if (ins) begin
                n_used[f_idx]  = 1'b1;
                n_ready[f_idx] = 1'b0;
            end
            if (flush) begin
                n_used = '0;
            end
            if (fill_ok && (e_pend == sptft_pkg::CNT_W'(1))) begin
                n_ready[r_m_idx] = 1'b1;
            end
            if (cup_ok) begin
                n_ready[r_m_idx] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_ready <= '0;
            r_occ   <= '0;
        end else begin
            r_used  <= n_used;
            r_ready <= n_ready;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_b_sel && ins) begin
            r_tag[f_idx] <= i_b_item.tile_address;
        end
    end

endmodule

// ----- sv/scratchpad_tile_fill_tracker_unit.sv -----
// top level: command register, bank lanes and result register
// the result strobe follows a taken start through the a, b and done registers
// throughput: one command per cycle, set by the tag compare and
// the slot update; busy never rises and results cannot be stalled
// reset clears every slot mark and occupancy at once, no clearing pass,
// and returns the registers to 65536 bank bytes, 32 request bytes, no accumulate
module scratchpad_tile_fill_tracker_unit #(
    parameter int BANK_COUNT     = 2,
    parameter int SLOTS_PER_BANK = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  sptft_pkg::t_in_item                 i_item,
    output logic                                o_done,
    output sptft_pkg::t_out_item                o_result,
    input  logic                                i_cfg_we,
    input  logic [sptft_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sptft_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    // the bank field is one bit wide, so at most two banks are reachable
    localparam int LIVE_BANKS = (BANK_COUNT < 2) ? BANK_COUNT : 2;

    logic                   r_a_valid;
    sptft_pkg::t_in_item    r_a_item;
    logic                   r_b_valid;
    sptft_pkg::t_in_item    r_b_item;
    logic                   r_done;
    sptft_pkg::t_out_item   r_out;
    sptft_pkg::t_out_item   n_out;
    sptft_pkg::t_cfg        r_cfg;
    sptft_pkg::t_out_item   lane_res [LIVE_BANKS];
    logic                   accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bank_bytes      <= sptft_pkg::BANK_BYTES_RST;
            r_cfg.request_bytes   <= sptft_pkg::REQ_BYTES_RST;
            r_cfg.accumulate_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (sptft_pkg::t_cfg_idx'(i_cfg_index))
                sptft_pkg::CFG_BANK_BYTES: begin
                    r_cfg.bank_bytes <= i_cfg_wdata[sptft_pkg::BB_W-1:0];
                end
                sptft_pkg::CFG_REQUEST_BYTES: begin
                    r_cfg.request_bytes <= i_cfg_wdata[sptft_pkg::RB_W-1:0];
                end
                sptft_pkg::CFG_ACCUMULATE: begin
                    r_cfg.accumulate_mode <= i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            r_done    <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_item <= i_item;
        r_b_item <= r_a_item;
        r_out    <= n_out;
    end

    for (genvar g = 0; g < LIVE_BANKS; g++) begin : g_bank
        sptft_bank #(
            .SLOTS (SLOTS_PER_BANK)
        ) u_bank (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_a_sel  (r_a_valid && (r_a_item.bank == 1'(g))),
            .i_a_addr (r_a_item.tile_address),
            .i_b_sel  (r_b_valid && (r_b_item.bank == 1'(g))),
            .i_b_item (r_b_item),
            .i_cfg    (r_cfg),
            .o_res    (lane_res[g])
        );
    end

    // a beat for a bank that does not exist reports not allocated, rest zero
    always_comb begin
        n_out        = '0;
        n_out.status = sptft_pkg::ST_NOT_ALLOCATED;
        for (int i = 0; i < LIVE_BANKS; i++) begin
            if (r_b_item.bank == 1'(i)) begin
                n_out = lane_res[i];
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

// ----- tb/tile_tracker_checker.sv -----
`timescale 1ns / 1ps
// checker for the tile fill tracker: predicts each command beat and compares results
module tile_tracker_checker #(
    parameter int BANKS = 2,
    parameter int SLOTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  sptft_pkg::t_in_item                 cmd_beat,
    input  logic                                done,
    input  sptft_pkg::t_out_item                result_beat,
    input  logic                                cfg_we,
    input  logic [sptft_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sptft_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output int                                  fail_count,
    output int                                  waiting_count,
    output int                                  checked_count,
    output logic [7:0]                          status_seen
);
    import sptft_pkg::*;

    // tile table as the block should hold it
    logic              tag_valid [BANKS][SLOTS];
    logic [ADDR_W-1:0] tag_addr  [BANKS][SLOTS];
    logic              tag_rdy   [BANKS][SLOTS];
    logic [SIZE_W-1:0] tag_size  [BANKS][SLOTS];
    logic [CNT_W-1:0]  tag_left  [BANKS][SLOTS];
    logic [OCC_W-1:0]  occ_units [BANKS];

    logic [BB_W-1:0]   cap_bytes;
    logic [RB_W-1:0]   unit_bytes;
    logic              accum_on;

    t_out_item         tile_result_q[$];

    int                n_fail = 0;
    int                n_checked = 0;
    logic [7:0]        codes_seen = '0;

    assign fail_count    = n_fail;
    assign waiting_count = tile_result_q.size();
    assign checked_count = n_checked;
    assign status_seen   = codes_seen;

    task automatic clear_table();
        for (int b = 0; b < BANKS; b++) begin
            for (int s = 0; s < SLOTS; s++) begin
                tag_valid[b][s] = 1'b0;
                tag_rdy[b][s]   = 1'b0;
            end
            occ_units[b] = '0;
        end
        cap_bytes  = BANK_BYTES_RST;
        unit_bytes = REQ_BYTES_RST;
        accum_on   = 1'b0;
        tile_result_q.delete();
    endtask

    function automatic int find_tile(int b, logic [ADDR_W-1:0] addr);
        for (int s = 0; s < SLOTS; s++)
            if (tag_valid[b][s] && tag_addr[b][s] == addr) return s;
        return -1;
    endfunction

    function automatic int lowest_free(int b);
        for (int s = 0; s < SLOTS; s++)
            if (!tag_valid[b][s]) return s;
        return -1;
    endfunction

    // 24-bit occupancy limit first, then the byte capacity
    function automatic bit has_room(int b, logic [SIZE_W-1:0] units);
        longint unsigned total;
        total = longint'(occ_units[b]) + longint'(units);
        if (total > longint'(OCC_MAX)) return 1'b0;
        return (total * longint'(unit_bytes)) <= longint'(cap_bytes);
    endfunction

    function automatic t_out_item tile_table_step(t_in_item it);
        t_out_item r;
        int        b;
        int        s;
        int        f;
        r = '0;
        r.status = ST_OK;
        b = int'(it.bank);
        s = find_tile(b, it.tile_address);
        case (it.command)
            CMD_ALLOCATE: begin
                if (s >= 0) begin
                    if (!accum_on)
                        r.status = ST_DUPLICATE;
                    else if (tag_size[b][s] != it.size_units)
                        r.status = ST_SIZE_MISMATCH;
                end else if (!has_room(b, it.size_units)) begin
                    r.status = ST_NO_ROOM;
                end else begin
                    f = lowest_free(b);
                    if (f < 0) begin
                        r.status = ST_TABLE_FULL;
                    end else begin
                        tag_valid[b][f] = 1'b1;
                        tag_addr[b][f]  = it.tile_address;
                        tag_rdy[b][f]   = 1'b0;
                        tag_size[b][f]  = it.size_units;
                        tag_left[b][f]  = it.request_count;
                        occ_units[b]    = occ_units[b] + OCC_W'(it.size_units);
                        r.newly_allocated = 1'b1;
                    end
                end
            end
            CMD_FILL: begin
                if (s < 0) begin
                    r.status = ST_NOT_ALLOCATED;
                end else if (tag_rdy[b][s] || tag_left[b][s] == '0) begin
                    r.status = ST_NOT_PENDING;
                end else begin
                    tag_left[b][s] = tag_left[b][s] - 1'b1;
                    if (tag_left[b][s] == '0) tag_rdy[b][s] = 1'b1;
                end
            end
            CMD_COUNT_UP: begin
                if (s < 0) begin
                    r.status = ST_NOT_ALLOCATED;
                end else begin
                    // saturates, request_count plays no part
                    if (tag_left[b][s] != '1) tag_left[b][s] = tag_left[b][s] + 1'b1;
                    tag_rdy[b][s] = 1'b0;
                end
            end
            CMD_FLUSH: begin
                for (int k = 0; k < SLOTS; k++) tag_valid[b][k] = 1'b0;
                occ_units[b] = '0;
            end
            default: ;
        endcase
        s = find_tile(b, it.tile_address);
        r.present         = (s >= 0);
        r.hit             = (s >= 0) ? tag_rdy[b][s] : 1'b0;
        r.fits            = has_room(b, it.size_units);
        r.below_capacity  = (longint'(occ_units[b]) * longint'(unit_bytes))
                            < longint'(cap_bytes);
        r.occupancy_units = occ_units[b];
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        n_fail++;
        $display("mismatch %0d at result %0d: %s got %0h want %0h",
                 n_fail, n_checked, what, got, want);
    endtask

    task automatic compare_result(t_out_item got, t_out_item want);
        if (got.status !== want.status)
            flag_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.newly_allocated !== want.newly_allocated)
            flag_mismatch("newly_allocated", 32'(got.newly_allocated),
                          32'(want.newly_allocated));
        if (got.hit !== want.hit)
            flag_mismatch("hit", 32'(got.hit), 32'(want.hit));
        if (got.present !== want.present)
            flag_mismatch("present", 32'(got.present), 32'(want.present));
        if (got.fits !== want.fits)
            flag_mismatch("fits", 32'(got.fits), 32'(want.fits));
        if (got.below_capacity !== want.below_capacity)
            flag_mismatch("below_capacity", 32'(got.below_capacity),
                          32'(want.below_capacity));
        if (got.occupancy_units !== want.occupancy_units)
            flag_mismatch("occupancy_units", 32'(got.occupancy_units),
                          32'(want.occupancy_units));
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_table();
        end else begin
            if (done) begin
                if (tile_result_q.size() == 0) begin
                    flag_mismatch("result beat with no command waiting", 32'(result_beat), 0);
                end else begin
                    want = tile_result_q.pop_front();
                    compare_result(result_beat, want);
                    codes_seen[want.status] = 1'b1;
                end
                n_checked++;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BANK_BYTES:    cap_bytes  = cfg_wdata[BB_W-1:0];
                    CFG_REQUEST_BYTES: unit_bytes = cfg_wdata[RB_W-1:0];
                    CFG_ACCUMULATE:    accum_on   = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (start && !busy)
                tile_result_q.push_back(tile_table_step(cmd_beat));
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top: clock, reset, command stimulus, register settings and verdict
module tb_top;
    import sptft_pkg::*;

    localparam int LATENCY     = 3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ADDR_POOL   = 100;
    localparam int PHASE_CMDS  = 190;

    localparam logic [CMD_W-1:0] CMD_SPARE      = 3'd7;
    localparam logic [BB_W-1:0]  BANK_BYTES_MAX = BB_W'(16777216);
    localparam logic [BB_W-1:0]  BANK_BYTES_MIN = '0;
    localparam logic [RB_W-1:0]  REQ_BYTES_MIN  = RB_W'(1);
    localparam logic [RB_W-1:0]  REQ_BYTES_MAX  = RB_W'(256);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_in_item              i_item = '0;
    logic                  o_done;
    t_out_item             o_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    int                    fail_count;
    int                    waiting_count;
    int                    checked_count;
    logic [7:0]            status_seen;
    int                    cmds_sent = 0;
    int                    cycle_count = 0;

    logic [ADDR_W-1:0]     addr_pool [2][ADDR_POOL];

    always #6 i_clk = ~i_clk;

    scratchpad_tile_fill_tracker_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    tile_tracker_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .cmd_beat      (i_item),
        .done          (o_done),
        .result_beat   (o_result),
        .cfg_we        (i_cfg_we),
        .cfg_index     (i_cfg_index),
        .cfg_wdata     (i_cfg_wdata),
        .fail_count    (fail_count),
        .waiting_count (waiting_count),
        .checked_count (checked_count),
        .status_seen   (status_seen)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, waiting_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_in_item mk_cmd(logic [CMD_W-1:0] cmd, logic bank,
                                        logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] size,
                                        logic [CNT_W-1:0] count);
        t_in_item it;
        it.command       = cmd;
        it.bank          = bank;
        it.tile_address  = addr;
        it.size_units    = size;
        it.request_count = count;
        return it;
    endfunction

    // busy is sampled at the falling edge before the taking edge
    task automatic issue_cmd(input t_in_item it);
        logic taken;
        start  <= 1'b1;
        i_item <= it;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        cmds_sent++;
    endtask

    task automatic drain();
        do @(negedge i_clk); while (waiting_count != 0);
        @(posedge i_clk);
    endtask

    task automatic write_config(input logic [BB_W-1:0] bb, input logic [RB_W-1:0] rb,
                                input logic acc);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BANK_BYTES;
        i_cfg_wdata <= CFG_DATA_W'(bb);
        @(posedge i_clk);
        i_cfg_index <= CFG_REQUEST_BYTES;
        i_cfg_wdata <= CFG_DATA_W'(rb);
        @(posedge i_clk);
        i_cfg_index <= CFG_ACCUMULATE;
        i_cfg_wdata <= CFG_DATA_W'(acc);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly pool addresses so allocate, fill and count-up meet the same tiles
    function automatic t_in_item random_cmd(int alloc_w, int flush_w, int bank1_pct);
        t_in_item it;
        int       pick;
        int       roll;
        it.bank = ($urandom_range(0, 99) < bank1_pct);
        if ($urandom_range(0, 9) == 0)
            it.tile_address = ADDR_W'({$urandom(), $urandom()});
        else
            it.tile_address = addr_pool[it.bank][$urandom_range(0, ADDR_POOL - 1)];
        pick = $urandom_range(0, alloc_w + flush_w + 66);
        if (pick < alloc_w) begin
            it.command = CMD_ALLOCATE;
        end else if (pick < alloc_w + flush_w) begin
            it.command = CMD_FLUSH;
        end else begin
            pick = pick - alloc_w - flush_w;
            if (pick < 28)      it.command = CMD_FILL;
            else if (pick < 36) it.command = CMD_COUNT_UP;
            else if (pick < 46) it.command = CMD_LOOKUP;
            else if (pick < 56) it.command = CMD_PRESENT;
            else if (pick < 66) it.command = CMD_ROOM;
            else                it.command = CMD_SPARE;
        end
        roll = $urandom_range(0, 9);
        if (roll < 7)      it.size_units = SIZE_W'($urandom_range(0, 48));
        else if (roll < 9) it.size_units = SIZE_W'($urandom_range(0, 512));
        else               it.size_units = SIZE_W'($urandom());
        roll = $urandom_range(0, 9);
        if (roll < 7)      it.request_count = CNT_W'($urandom_range(0, 3));
        else if (roll < 9) it.request_count = CNT_W'($urandom_range(0, 40));
        else               it.request_count = CNT_W'($urandom());
        return it;
    endfunction

    task automatic run_phase(input logic [BB_W-1:0] bb, input logic [RB_W-1:0] rb,
                             input logic acc, input int alloc_w, input int flush_w,
                             input int bank1_pct);
        int burst_left;
        int gap;
        int k;
        drain();
        write_config(bb, rb, acc);
        burst_left = 0;
        for (k = 0; k < PHASE_CMDS; k++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            issue_cmd(random_cmd(alloc_w, flush_w, bank1_pct));
        end
        start <= 1'b0;
    endtask

    initial begin
        logic [ADDR_W-1:0] tile_a;
        logic [ADDR_W-1:0] tile_b;
        logic [ADDR_W-1:0] tile_c;

        for (int b = 0; b < 2; b++)
            for (int p = 0; p < ADDR_POOL; p++)
                addr_pool[b][p] = ADDR_W'({$urandom(), $urandom()});
        tile_a = '0;
        tile_b = '1;
        tile_c = ADDR_W'({$urandom(), $urandom()});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass under the reset register values
        issue_cmd(mk_cmd(CMD_ROOM,     1'b0, tile_a, '1, '0));
        issue_cmd(mk_cmd(CMD_LOOKUP,   1'b0, tile_b, '0, '0));
        issue_cmd(mk_cmd(CMD_FILL,     1'b0, tile_a, '0, '0));
        issue_cmd(mk_cmd(CMD_COUNT_UP, 1'b0, tile_a, '0, '0));
        issue_cmd(mk_cmd(CMD_ALLOCATE, 1'b0, tile_a, 16'd16, 16'd2));
        issue_cmd(mk_cmd(CMD_ALLOCATE, 1'b0, tile_a, 16'd16, 16'd2));
        issue_cmd(mk_cmd(CMD_FILL,     1'b0, tile_a, '0, '0));
        issue_cmd(mk_cmd(CMD_FILL,     1'b0, tile_a, '0, '0));
        issue_cmd(mk_cmd(CMD_FILL,     1'b0, tile_a, '0, '0));
        issue_cmd(mk_cmd(CMD_COUNT_UP, 1'b0, tile_a, '0, '1));
        // zero fills: not ready until a count-up and a fill
        issue_cmd(mk_cmd(CMD_ALLOCATE, 1'b0, tile_b, '0, '0));
        issue_cmd(mk_cmd(CMD_FILL,     1'b0, tile_b, '0, '0));
        issue_cmd(mk_cmd(CMD_COUNT_UP, 1'b0, tile_b, '0, '0));
        issue_cmd(mk_cmd(CMD_FILL,     1'b0, tile_b, '0, '0));
        issue_cmd(mk_cmd(CMD_ALLOCATE, 1'b1, tile_c, '1, '1));
        // exactly fills the bank at the reset capacity
        issue_cmd(mk_cmd(CMD_ALLOCATE, 1'b1, tile_c, 16'd2048, '1));
        issue_cmd(mk_cmd(CMD_COUNT_UP, 1'b1, tile_c, '0, '0));
        issue_cmd(mk_cmd(CMD_ROOM,     1'b1, tile_c, '0, '0));
        issue_cmd(mk_cmd(CMD_PRESENT,  1'b1, tile_c, '0, '0));
        issue_cmd(mk_cmd(CMD_SPARE,    1'b1, tile_c, '1, '1));
        issue_cmd(mk_cmd(CMD_FLUSH,    1'b1, tile_c, '0, '0));
        issue_cmd(mk_cmd(CMD_PRESENT,  1'b1, tile_c, '0, '0));
        start <= 1'b0;
        drain();
        write_config(BANK_BYTES_RST, REQ_BYTES_RST, 1'b1);
        issue_cmd(mk_cmd(CMD_ALLOCATE, 1'b0, tile_a, 16'd16, '0));
        issue_cmd(mk_cmd(CMD_ALLOCATE, 1'b0, tile_a, 16'd17, '0));
        start <= 1'b0;

        run_phase(BANK_BYTES_RST, REQ_BYTES_RST, 1'b0, 30, 2, 50);
        // huge capacity and no flushes so bank 0 runs out of slots
        run_phase(BANK_BYTES_MAX, REQ_BYTES_MIN, 1'b1, 90, 0, 5);
        run_phase(BANK_BYTES_MIN, REQ_BYTES_MAX, 1'b0, 30, 2, 50);
        run_phase(BB_W'($urandom_range(0, 16777216)), RB_W'($urandom_range(1, 256)),
                  1'($urandom_range(0, 1)), 35, 3, 50);
        run_phase(BB_W'($urandom_range(0, 65536)), RB_W'($urandom_range(1, 256)),
                  1'($urandom_range(0, 1)), 35, 3, 50);

        do @(negedge i_clk); while (waiting_count != 0);
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("sent %0d commands across 7 register settings, checked %0d results",
                 cmds_sent, checked_count);
        $display("status codes observed (bit per code, code 0 on the right): %b",
                 status_seen);
        if (fail_count == 0 && waiting_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
